// ===== hdl/fdfd_pkg.sv =====
// Shared types and constants for the flag-delimited frame decoder.
`timescale 1ns / 1ps

package fdfd_pkg;

  localparam int DEF_PORTS     = 5;
  localparam int DEF_MAX_FRAME = 256;

  localparam int PORT_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 9;
  localparam int LIMIT_W = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h5D;
  localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h5E;

  // result queue: an item can add two results, so depth 4 keeps one item in flight
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    status_t           status;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              last;
  } result_t;

  // results produced by one item, first in r0
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

endpackage

// ===== hdl/flag_delimited_frame_decoder.sv =====
// Top level of the flag-delimited frame decoder: input register, decode, result queue.
`timescale 1ns / 1ps

// Byte un-stuffing deframer with one frame state per port. Each input item is a
// received byte with its port; an item is held in the input register, is decoded
// combinationally against its port's state and leaves zero, one or two results
// in a four-entry queue. Items are taken one per cycle as long as the queue has
// two free slots; results leave one per cycle while m_axis_tready is high, so the
// sustained rate is one item per cycle unless items produce two results faster
// than they drain. tuser carries the status (0 data, 1 frame done, 2 overflow
// drop), tlast marks the last result of an item. The user must write frame_limit
// through cfg_wr_en only while the block is idle; the block does not enforce it.
module flag_delimited_frame_decoder import fdfd_pkg::*; #(
  parameter int PORTS     = DEF_PORTS,
  parameter int MAX_FRAME = DEF_MAX_FRAME
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,   // frame_limit
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // port[2:0], rx_byte[10:3], zero pad
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,  // out_port[2:0], data_byte[10:3],
                                            // frame_length[19:11], zero pad
  output logic [1:0]         m_axis_tuser,  // status
  output logic               m_axis_tlast   // last
);

  logic [LIMIT_W-1:0] frame_limit;
  logic               in_valid;
  logic [PORT_W-1:0]  in_port;
  logic [BYTE_W-1:0]  in_byte;
  logic               room, advance;
  dec_out_t           dec_res, push;
  result_t            head_res;

  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      frame_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_port <= s_axis_tdata[PORT_W-1:0];
      in_byte <= s_axis_tdata[PORT_W+BYTE_W-1:PORT_W];
    end
  end

  fdfd_decode #(
    .PORTS     (PORTS),
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .go          (advance),
    .port        (in_port),
    .rx_byte     (in_byte),
    .frame_limit (frame_limit),
    .res         (dec_res)
  );

  always_comb begin
    push = dec_res;
    if (!advance) push.count = 2'd0;
  end

  fdfd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (head_res)
  );

  assign m_axis_tdata = {4'b0, head_res.length, head_res.data, head_res.port};
  assign m_axis_tuser = head_res.status;
  assign m_axis_tlast = head_res.last;

endmodule

// ===== hdl/fdfd_decode.sv =====
// Per-port frame state and combinational decode of one received byte.
`timescale 1ns / 1ps

module fdfd_decode import fdfd_pkg::*; #(
  parameter int PORTS     = DEF_PORTS,
  parameter int MAX_FRAME = DEF_MAX_FRAME
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [PORT_W-1:0]  port,
  input  logic [BYTE_W-1:0]  rx_byte,
  input  logic [LIMIT_W-1:0] frame_limit,
  output dec_out_t           res
);

  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int CW  = $clog2(MAX_FRAME + 1);
  localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [LW-1:0] MAX_W = LW'(MAX_FRAME);

  logic          in_frame       [PORTS];
  logic [CW-1:0] raw_count      [PORTS];
  logic          escape_pending [PORTS];
  logic [CW-1:0] decoded_count  [PORTS];

  logic [PIW-1:0] idx;
  logic           port_ok;
  logic           cur_inf, cur_esc;
  logic [CW-1:0]  cur_raw, cur_dec;
  logic           inf_next, esc_next;
  logic [CW-1:0]  raw_next, dec_next;
  logic [CW-1:0]  dec_close;
  logic [LW-1:0]  lim_w, lim_eff;
  logic           at_limit;

  assign idx     = PIW'(port);
  assign port_ok = 32'(port) < PORTS;
  assign cur_inf = in_frame[idx];
  assign cur_esc = escape_pending[idx];
  assign cur_raw = raw_count[idx];
  assign cur_dec = decoded_count[idx];

  assign lim_w    = LW'(frame_limit);
  assign lim_eff  = (lim_w > MAX_W) ? MAX_W : lim_w;
  assign at_limit = LW'(cur_raw) >= lim_eff;
  assign dec_close = cur_dec + CW'(cur_esc);

  always_comb begin
    inf_next = cur_inf;
    esc_next = cur_esc;
    raw_next = cur_raw;
    dec_next = cur_dec;
    res.count = 2'd0;
    res.r0 = '{port: port, status: ST_DATA, data: '0, length: '0, last: 1'b0};
    res.r1 = '{port: port, status: ST_DATA, data: '0, length: '0, last: 1'b0};
    if (port_ok) begin
      if (rx_byte == FLAG_BYTE) begin
        if (!cur_inf) begin
          inf_next = 1'b1;
          esc_next = 1'b0;
          raw_next = '0;
          dec_next = '0;
        end else begin
          esc_next = 1'b0;
          if (cur_esc) begin
            // dangling escape: hand out the raw escape byte before closing
            res.count     = 2'd2;
            res.r0.data   = ESC_BYTE;
            res.r1.status = ST_DONE;
            res.r1.length = LEN_W'(dec_close);
            res.r1.last   = 1'b1;
          end else begin
            res.count     = 2'd1;
            res.r0.status = ST_DONE;
            res.r0.length = LEN_W'(dec_close);
            res.r0.last   = 1'b1;
          end
          if (cur_raw != '0) begin
            inf_next = 1'b0;
            raw_next = '0;
            dec_next = '0;
          end else begin
            // empty frame stays open
            dec_next = dec_close;
          end
        end
      end else if (cur_inf) begin
        if (at_limit) begin
          res.count     = 2'd1;
          res.r0.status = ST_OVER;
          res.r0.last   = 1'b1;
        end else begin
          raw_next = cur_raw + 1'b1;
          if (cur_esc) begin
            esc_next = 1'b0;
            if (rx_byte == ESC_FLAG || rx_byte == ESC_BYTE) begin
              res.count   = 2'd1;
              res.r0.data = (rx_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;
              res.r0.last = 1'b1;
              dec_next    = cur_dec + 1'b1;
            end
          end else if (rx_byte == ESC_BYTE) begin
            esc_next = 1'b1;
          end else begin
            res.count   = 2'd1;
            res.r0.data = rx_byte;
            res.r0.last = 1'b1;
            dec_next    = cur_dec + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORTS; i++) begin
        in_frame[i]       <= 1'b0;
        raw_count[i]      <= '0;
        escape_pending[i] <= 1'b0;
        decoded_count[i]  <= '0;
      end
    end else if (go && port_ok) begin
      in_frame[idx]       <= inf_next;
      raw_count[idx]      <= raw_next;
      escape_pending[idx] <= esc_next;
      decoded_count[idx]  <= dec_next;
    end
  end

  a_two_results_order: assert property (@(posedge clk) disable iff (rst)
    (go && res.count == 2'd2) |-> (res.r0.status == ST_DATA && res.r1.status == ST_DONE))
    else $error("two results must be escape byte then frame done");

  a_raw_bounded: assert property (@(posedge clk) disable iff (rst)
    (go && port_ok) |-> (LW'(cur_raw) <= MAX_W))
    else $error("raw count beyond frame maximum");

  a_idle_no_escape: assert property (@(posedge clk) disable iff (rst)
    (go && port_ok && !cur_inf) |-> !cur_esc)
    else $error("escape pending on idle port");

endmodule

// ===== hdl/fdfd_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
`timescale 1ns / 1ps

module fdfd_result_fifo import fdfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dec_out_t push,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head, tail;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign out_valid = count != '0;
  assign out_res   = mem[head];
  assign pop       = out_valid && out_ready;
  // two free slots needed whatever the item turns out to produce
  assign room      = count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[tail] <= push.r0;
    if (push.count == 2'd2) mem[tail + 1'b1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + FIFO_AW'(push.count);
      head  <= head + FIFO_AW'(pop);
      count <= count + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push into result queue without room");

  a_pair_count: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2 && !pop) |=> count == $past(count) + 2'd2)
    else $error("result count lost on double push");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!push.r0.last && push.r1.last))
    else $error("last flag misplaced on result pair");

endmodule
